>>> hw/rtl/console_line_editor_defines.svh
// Assertion macros for the console line editor RTL.
`ifndef CONSOLE_LINE_EDITOR_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define CLE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define CLE_ASSERT_NEXT(lbl, trig, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (post)) \
      else $error(msg);

`endif

>>> hw/rtl/cle_pkg.sv
package cle_pkg;

   localparam int RING_DEPTH_DEF = 128;

   localparam logic [7:0] KEY_INTR = 8'h03;
   localparam logic [7:0] KEY_EOF  = 8'h04;
   localparam logic [7:0] KEY_BACK = 8'h08;
   localparam logic [7:0] KEY_DUMP = 8'h10;
   localparam logic [7:0] KEY_KILL = 8'h15;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] KEY_NUL  = 8'h00;

   localparam logic [8:0] ERASE_CODE = 9'h100;
   localparam logic [8:0] ECHO_CARET = 9'h05E;
   localparam logic [8:0] ECHO_C     = 9'h043;
   localparam logic [7:0] ECHO_COUNT_MAX = 8'd255;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_INTR
   } cle_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_key;    // key transfer: act on it and load its first result
      logic issue_read;  // read transfer: start the ring read
      logic load_read;   // ring data is back: load the read result
      logic load_intr2;  // load the second interrupt result
   } cle_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_read;
      logic is_intr;
      logic out_free;
   } cle_sts_type;

   // Result payload, last field in the lowest bits.
   typedef struct packed {
      logic [6:0] pad;
      logic       read_empty;
      logic       read_stop;
      logic [7:0] read_char;
      logic       read_valid;
      logic       dump_seen;
      logic       interrupt_seen;
      logic       line_ready;
      logic       serial_erase;
      logic [7:0] echo_count;
      logic [8:0] echo_char;
      logic       echo_valid;
   } cle_result_type;

endpackage

>>> hw/rtl/cle_ram.sv
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/cle_ctrl.sv
module cle_ctrl import cle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  cle_sts_type sts,
   output cle_cmd_type cmd
);

   cle_state_type state_ff;
   cle_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = sts.out_free;
            if (req_tvalid && sts.out_free) begin
               if (sts.is_read) begin
                  cmd.issue_read = 1'b1;
                  state_in       = ST_READ;
               end else begin
                  cmd.load_key = 1'b1;
                  if (sts.is_intr) begin
                     state_in = ST_INTR;
                  end
               end
            end
         end
         ST_READ: begin
            if (sts.out_free) begin
               cmd.load_read = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_INTR: begin
            if (sts.out_free) begin
               cmd.load_intr2 = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/cle_dp.sv
`include "console_line_editor_defines.svh"

module cle_dp import cle_pkg::*; #(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] req_tdata,
   input  logic        req_tuser,
   input  logic        csr_valid,
   input  logic        csr_data,
   input  cle_cmd_type cmd,
   output cle_sts_type sts,
   output logic        rsp_tvalid,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        rsp_tready
);

   localparam int IDX_MOD = 2 * RING_DEPTH;
   localparam int IDX_W   = $clog2(IDX_MOD);
   localparam int SLOT_W  = $clog2(RING_DEPTH);
   localparam int CNT_W   = (IDX_W > 8) ? IDX_W : 8;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
      return (x == IDX_W'(IDX_MOD - 1)) ? '0 : x + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] x);
      return (x == '0) ? IDX_W'(IDX_MOD - 1) : x - 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] idx_slot(input logic [IDX_W-1:0] x);
      return (x >= IDX_W'(RING_DEPTH)) ? SLOT_W'(x - IDX_W'(RING_DEPTH)) : SLOT_W'(x);
   endfunction

   // Wraps modulo twice the depth; a power-of-two modulus wraps by itself.
   function automatic logic [IDX_W-1:0] idx_diff(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      return (a >= b) ? a - b : a + IDX_W'(IDX_MOD) - b;
   endfunction

   logic [IDX_W-1:0] read_ff, read_in;
   logic [IDX_W-1:0] commit_ff, commit_in;
   logic [IDX_W-1:0] edit_ff, edit_in;
   logic             echo_ff;
   logic             first_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   cle_result_type   rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [7:0]       key;
   logic [7:0]       stored;
   logic [IDX_W-1:0] edit_inc;
   logic [IDX_W-1:0] occ_edit;
   logic [IDX_W-1:0] occ_commit;
   logic [IDX_W-1:0] uncommitted;
   logic [CNT_W-1:0] kill_wide;
   logic [7:0]       kill_cnt;
   logic             room;
   logic             out_free;

   cle_result_type   key_res, rd_res, intr_res;
   logic [IDX_W-1:0] key_edit, key_commit, rd_read;
   logic             key_we;
   logic [7:0]       ram_rdata;

   assign key         = req_tdata[7:0];
   assign stored      = (key == CH_CR) ? CH_LF : key;
   assign edit_inc    = idx_inc(edit_ff);
   assign occ_edit    = idx_diff(edit_ff, read_ff);
   assign occ_commit  = idx_diff(commit_ff, read_ff);
   assign uncommitted = idx_diff(edit_ff, commit_ff);
   assign room        = occ_edit < IDX_W'(RING_DEPTH);
   assign kill_wide   = CNT_W'(uncommitted);
   assign kill_cnt    = (kill_wide > CNT_W'(ECHO_COUNT_MAX)) ? ECHO_COUNT_MAX
                                                             : kill_wide[7:0];
   assign out_free    = !rsp_valid_ff || rsp_tready;

   assign sts.is_read  = req_tuser;
   assign sts.is_intr  = (key == KEY_INTR);
   assign sts.out_free = out_free;

   cle_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.load_key && key_we),
      .wr_addr (idx_slot(edit_ff)),
      .wr_data (stored),
      .rd_en   (cmd.issue_read),
      .rd_addr (idx_slot(read_ff)),
      .rd_data (ram_rdata)
   );

   // Key handling. The uncommitted tail never holds a newline (one commits
   // at once), so kill-line erases exactly back to the commit point.
   always_comb begin
      key_res    = '0;
      key_edit   = edit_ff;
      key_commit = commit_ff;
      key_we     = 1'b0;
      unique case (key)
         KEY_DUMP: begin
            key_res.dump_seen = 1'b1;
         end
         KEY_KILL: begin
            key_edit           = commit_ff;
            key_res.echo_valid = echo_ff && (kill_cnt != '0);
            key_res.echo_char  = ERASE_CODE;
            key_res.echo_count = kill_cnt;
         end
         KEY_BACK: begin
            if (edit_ff != commit_ff) begin
               key_edit             = idx_dec(edit_ff);
               key_res.serial_erase = 1'b1;
               key_res.echo_valid   = echo_ff;
               key_res.echo_char    = ERASE_CODE;
               key_res.echo_count   = 8'd1;
            end
         end
         KEY_INTR: begin
            key_res.echo_valid = 1'b1;
            key_res.echo_char  = ECHO_CARET;
            key_res.echo_count = 8'd1;
         end
         default: begin
            if (key != KEY_NUL && room) begin
               key_we             = 1'b1;
               key_edit           = edit_inc;
               key_res.echo_valid = echo_ff;
               key_res.echo_char  = (stored == KEY_EOF) ? {1'b0, CH_LF} : {1'b0, stored};
               key_res.echo_count = 8'd1;
               if (stored == CH_LF || stored == KEY_EOF ||
                   idx_diff(edit_inc, read_ff) == IDX_W'(RING_DEPTH)) begin
                  key_commit         = edit_inc;
                  key_res.line_ready = 1'b1;
               end
            end
         end
      endcase
   end

   always_comb begin
      intr_res                = '0;
      intr_res.echo_valid     = 1'b1;
      intr_res.echo_char      = ECHO_C;
      intr_res.echo_count     = 8'd1;
      intr_res.interrupt_seen = 1'b1;
   end

   // Read handling on the registered ring data.
   always_comb begin
      rd_res  = '0;
      rd_read = read_ff;
      if (read_ff == commit_ff) begin
         rd_res.read_empty = 1'b1;
      end else if (ram_rdata == KEY_EOF) begin
         rd_res.read_stop = 1'b1;
         if (first_ff) begin
            rd_read = idx_inc(read_ff);
         end
      end else begin
         rd_read           = idx_inc(read_ff);
         rd_res.read_valid = 1'b1;
         rd_res.read_char  = ram_rdata;
         rd_res.read_stop  = (ram_rdata == CH_LF);
      end
   end

   always_comb begin
      read_in      = read_ff;
      commit_in    = commit_ff;
      edit_in      = edit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load_key) begin
         edit_in      = key_edit;
         commit_in    = key_commit;
         rsp_valid_in = 1'b1;
         rsp_data_in  = key_res;
         rsp_last_in  = (key != KEY_INTR);
      end else if (cmd.load_read) begin
         read_in      = rd_read;
         rsp_valid_in = 1'b1;
         rsp_data_in  = rd_res;
         rsp_last_in  = 1'b1;
      end else if (cmd.load_intr2) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = intr_res;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_ff      <= '0;
         commit_ff    <= '0;
         edit_ff      <= '0;
         echo_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         read_ff      <= read_in;
         commit_ff    <= commit_in;
         edit_ff      <= edit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            echo_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (cmd.issue_read) begin
         first_ff <= req_tdata[8];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `CLE_ASSERT(a_ring_bound, occ_edit <= IDX_W'(RING_DEPTH), "ring holds more than its depth")
   `CLE_ASSERT(a_commit_order, occ_commit <= occ_edit, "commit point beyond edit point")
   `CLE_ASSERT_NEXT(a_kill_clears, cmd.load_key && key == KEY_KILL, edit_ff == commit_ff, "kill-line left uncommitted bytes")

endmodule

>>> hw/rtl/console_line_editor.sv
// A key transfer gives its result in the output register in the next cycle;
// a read transfer goes through the registered ring read, then the output register once free.
// Ctrl-C gives two results on consecutive free output cycles.
// One key per cycle while the output drains; a ctrl-C or a read holds requests until it is done.
// Reset: indices cleared, echo on; ring contents stay undefined, no clearing pass.
module console_line_editor import cle_pkg::*; #(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] key_char, [8] first_of_read, [15:9] zero
   input  logic        req_tuser,   // [0] command: 0 typed key, 1 read one byte
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] echo_valid, [9:1] echo_char,
                                    // [17:10] echo_count, [18] serial_erase,
                                    // [19] line_ready, [20] interrupt_seen,
                                    // [21] dump_seen, [22] read_valid,
                                    // [30:23] read_char, [31] read_stop,
                                    // [32] read_empty, [39:33] zero
   output logic        rsp_tlast,
   // echo enable register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   cle_cmd_type cmd;
   cle_sts_type sts;

   // Register writes land at once; user sends them only while the block is idle (unenforced).
   assign csr_ready = 1'b1;

   // Sequencer: one transfer at a time; hold the request side while the output is busy,
   // a read waits on the ring and the output, or the second interrupt result waits for the output.
   cle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Indices, ring, echo register and the output register.
   cle_dp #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tready (rsp_tready)
   );

endmodule
